>>> src/tgad_pkg.sv
// Shared types, constants and helpers for the TGA run-length pixel decoder.
package tgad_pkg;

  localparam int DIM_W   = 11;
  localparam int ADDR_W  = 20;
  localparam int CNT_W   = 8;
  localparam int PIX_W   = 24;
  localparam int CIDX_W  = 2;

  localparam logic [DIM_W-1:0] MAX_WIDTH  = 11'd1024;
  localparam logic [DIM_W-1:0] MAX_HEIGHT = 11'd1024;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;
  // (480 - 1) * 640: start of the bottom row at reset
  localparam logic [ADDR_W-1:0] ROW_BASE_RST = 20'd306560;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // One input beat as it moves from the input register to the decoder
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       frame_start;
  } tgad_beat_t;

  // Zero is treated as one, anything past the limit as the limit
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                 logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    if (v == '0) r = 11'd1;
    else if (v > lim) r = lim;
    else r = v;
    return r;
  endfunction

endpackage

>>> src/tgad_in_reg.sv
// Input register stage: captures one stream beat and holds it until the decoder takes it.
module tgad_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_stream_byte,
  input  logic                 in_frame_start,
  output logic                 beat_valid,
  output tgad_pkg::tgad_beat_t beat,
  input  logic                 beat_take
);

  logic                 valid_r;
  tgad_pkg::tgad_beat_t beat_r;

  // Hold off the sender only while a beat sits here and cannot move on
  assign in_stall   = valid_r && !beat_take;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      valid_r <= 1'b1;
    end else if (beat_take) begin
      valid_r <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      beat_r.stream_byte <= in_stream_byte;
      beat_r.frame_start <= in_frame_start;
    end
  end

endmodule

>>> src/tgad_core.sv
// Packet decoder: configuration registers, packet/pixel/row state and the span result register.
module tgad_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_wr,
  input  logic [tgad_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [tgad_pkg::DIM_W-1:0]         cfg_data,
  // beat from the input register
  input  logic                               beat_valid,
  input  tgad_pkg::tgad_beat_t               beat,
  output logic                               beat_take,
  // span result
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tgad_pkg::ADDR_W-1:0]        out_span_address,
  output logic [tgad_pkg::CNT_W-1:0]         out_span_count,
  output logic [tgad_pkg::PIX_W-1:0]         out_pixel_value,
  output logic                               out_span_clipped,
  output logic                               out_image_done
);

  localparam int DW = tgad_pkg::DIM_W;
  localparam int AW = tgad_pkg::ADDR_W;

  // Configuration and derived start address
  logic [DW-1:0] width_r, height_r;
  logic [DW-1:0] w_c, h_c;
  logic [DW-1:0] width_src, height_src;
  logic [DW-1:0] w_src_c, h_src_c;
  logic [AW-1:0] base_src;
  logic [AW-1:0] init_base_r;
  logic          cfg_hit;

  // Decode state
  logic          expect_header_r, expect_header_nxt;
  logic          packet_is_run_r, packet_is_run_nxt;
  logic [7:0]    pixels_left_r,   pixels_left_nxt;
  logic [1:0]    byte_in_pixel_r, byte_in_pixel_nxt;
  logic [15:0]   partial_pixel_r, partial_pixel_nxt;
  logic [DW-1:0] column_r,        column_nxt;
  logic [AW-1:0] row_base_r,      row_base_nxt;
  logic [DW-1:0] rows_left_r,     rows_left_nxt;

  // Per-beat working values
  logic          emit, clipped, done, end_pkt;
  logic [DW-1:0] avail, n;
  logic [23:0]   value;
  logic [AW-1:0] addr;

  // Result register
  logic          out_valid_r;
  logic [AW-1:0] out_addr_r;
  logic [7:0]    out_cnt_r;
  logic [23:0]   out_pix_r;
  logic          out_clip_r, out_done_r;

  assign w_c     = tgad_pkg::clamp_dim(width_r,  tgad_pkg::MAX_WIDTH);
  assign h_c     = tgad_pkg::clamp_dim(height_r, tgad_pkg::MAX_HEIGHT);
  assign cfg_hit = cfg_wr && (cfg_index == tgad_pkg::CFG_IMAGE_WIDTH ||
                              cfg_index == tgad_pkg::CFG_IMAGE_HEIGHT);

  // Geometry as it stands after this cycle's write, and its bottom-row start
  assign width_src  = (cfg_wr && cfg_index == tgad_pkg::CFG_IMAGE_WIDTH) ? cfg_data : width_r;
  assign height_src = (cfg_wr && cfg_index == tgad_pkg::CFG_IMAGE_HEIGHT) ? cfg_data : height_r;
  assign w_src_c    = tgad_pkg::clamp_dim(width_src,  tgad_pkg::MAX_WIDTH);
  assign h_src_c    = tgad_pkg::clamp_dim(height_src, tgad_pkg::MAX_HEIGHT);
  assign base_src   = {{(AW-DW){1'b0}}, h_src_c - 11'd1} * {{(AW-DW){1'b0}}, w_src_c};

  // Beat moves on whenever the result register is free or draining
  assign beat_take = beat_valid && (!out_valid_r || !out_stall);

  // Configuration registers and bottom-row start address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= tgad_pkg::WIDTH_RST;
      height_r    <= tgad_pkg::HEIGHT_RST;
      init_base_r <= tgad_pkg::ROW_BASE_RST;
    end else begin
      width_r     <= width_src;
      height_r    <= height_src;
      init_base_r <= base_src;
    end
  end

  // Decode of one beat
  always_comb begin
    expect_header_nxt = expect_header_r;
    packet_is_run_nxt = packet_is_run_r;
    pixels_left_nxt   = pixels_left_r;
    byte_in_pixel_nxt = byte_in_pixel_r;
    partial_pixel_nxt = partial_pixel_r;
    column_nxt        = column_r;
    row_base_nxt      = row_base_r;
    rows_left_nxt     = rows_left_r;
    emit    = 1'b0;
    clipped = 1'b0;
    done    = 1'b0;
    end_pkt = 1'b0;
    avail   = '0;
    n       = '0;
    value   = {beat.stream_byte, partial_pixel_r};
    addr    = '0;

    // frame restart
    if (beat.frame_start) begin
      expect_header_nxt = 1'b1;
      packet_is_run_nxt = 1'b0;
      pixels_left_nxt   = '0;
      byte_in_pixel_nxt = '0;
      partial_pixel_nxt = '0;
      column_nxt        = '0;
      row_base_nxt      = init_base_r;
      rows_left_nxt     = h_c;
    end

    if (rows_left_nxt == '0) begin
      // image complete: drop the beat
    end else if (expect_header_nxt) begin
      packet_is_run_nxt = beat.stream_byte[7];
      pixels_left_nxt   = beat.stream_byte[7] ? {1'b0, beat.stream_byte[6:0]} + 8'd1
                                              : beat.stream_byte + 8'd1;
      byte_in_pixel_nxt = '0;
      partial_pixel_nxt = '0;
      expect_header_nxt = 1'b0;
    end else if (byte_in_pixel_nxt != 2'd2) begin
      if (byte_in_pixel_nxt == 2'd0) partial_pixel_nxt[7:0]  = beat.stream_byte;
      else                           partial_pixel_nxt[15:8] = beat.stream_byte;
      byte_in_pixel_nxt = byte_in_pixel_nxt + 2'd1;
    end else begin
      value             = {beat.stream_byte, partial_pixel_nxt};
      byte_in_pixel_nxt = '0;
      partial_pixel_nxt = '0;
      if (pixels_left_nxt == '0) begin
        end_pkt = 1'b1;
      end else begin
        avail = (column_nxt < w_c) ? w_c - column_nxt : '0;
        if (packet_is_run_nxt) begin
          n       = ({3'd0, pixels_left_nxt} < avail) ? {3'd0, pixels_left_nxt} : avail;
          clipped = {3'd0, pixels_left_nxt} > avail;
          pixels_left_nxt = '0;
        end else begin
          n       = (avail != '0) ? 11'd1 : 11'd0;
          pixels_left_nxt = pixels_left_nxt - 8'd1;
          clipped = (avail == 11'd1) && (pixels_left_nxt != '0);
        end
        if (n != '0) begin
          emit       = 1'b1;
          addr       = row_base_nxt + AW'(column_nxt);
          column_nxt = column_nxt + n;
          done       = (column_nxt >= w_c) && (rows_left_nxt == 11'd1);
        end
        end_pkt = (pixels_left_nxt == '0);
      end
    end

    // packet end, stepping up one row when this one is full
    if (end_pkt) begin
      expect_header_nxt = 1'b1;
      pixels_left_nxt   = '0;
      if (column_nxt >= w_c) begin
        column_nxt = '0;
        if (rows_left_nxt != '0) rows_left_nxt = rows_left_nxt - 11'd1;
        if (rows_left_nxt != '0) row_base_nxt = row_base_nxt - AW'(w_c);
      end
    end
  end

  // Decode state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_header_r <= 1'b1;
      packet_is_run_r <= 1'b0;
      pixels_left_r   <= '0;
      byte_in_pixel_r <= '0;
      partial_pixel_r <= '0;
      column_r        <= '0;
      row_base_r      <= tgad_pkg::ROW_BASE_RST;
      rows_left_r     <= tgad_pkg::HEIGHT_RST;
    end else if (cfg_hit) begin
      expect_header_r <= 1'b1;
      packet_is_run_r <= 1'b0;
      pixels_left_r   <= '0;
      byte_in_pixel_r <= '0;
      partial_pixel_r <= '0;
      column_r        <= '0;
      row_base_r      <= base_src;
      rows_left_r     <= h_src_c;
    end else if (beat_take) begin
      expect_header_r <= expect_header_nxt;
      packet_is_run_r <= packet_is_run_nxt;
      pixels_left_r   <= pixels_left_nxt;
      byte_in_pixel_r <= byte_in_pixel_nxt;
      partial_pixel_r <= partial_pixel_nxt;
      column_r        <= column_nxt;
      row_base_r      <= row_base_nxt;
      rows_left_r     <= rows_left_nxt;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (beat_take) begin
      out_valid_r <= emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (beat_take && emit) begin
      out_addr_r <= addr;
      out_cnt_r  <= n[7:0];
      out_pix_r  <= value;
      out_clip_r <= clipped;
      out_done_r <= done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_span_address = out_addr_r;
  assign out_span_count   = out_cnt_r;
  assign out_pixel_value  = out_pix_r;
  assign out_span_clipped = out_clip_r;
  assign out_image_done   = out_done_r;

  // Column never runs past the row end
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    column_r <= w_c)
    else $error("column past row end");

  // A span that is shown always writes at least one pixel
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cnt_r != '0)
    else $error("empty span emitted");

  // Waiting for a header means no pixels are owed from the last packet
  a_hdr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    expect_header_r |-> pixels_left_r == '0 && byte_in_pixel_r == '0)
    else $error("header expected with packet still open");

  // A decoded span reaches the result register on the next cycle
  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    beat_take && emit && !cfg_hit |=> out_valid_r)
    else $error("span lost");

endmodule

>>> src/tga_rle_pixel_decoder.sv
// Top level of the 24-bit TGA run-length pixel decoder.
// Takes one image-data byte per beat and emits span writes (address, count, pixel value,
// clip and image-done flags). A new byte is taken every cycle while in_stall is low; a
// byte moves from the input register through the packet decoder into the result
// register, which drives its span onto the output. in_stall rises only while the result
// register holds a span that the receiver is stalling. A write of image_width or
// image_height restarts decoding at the first row; the bottom-row start address comes
// from one 11x11 multiplier on the write itself, so bytes may follow at once.
module tga_rle_pixel_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tgad_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [tgad_pkg::DIM_W-1:0]          cfg_data,
  // byte stream
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_stream_byte,
  input  logic                                in_frame_start,
  // span writes
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tgad_pkg::ADDR_W-1:0]         out_span_address,
  output logic [tgad_pkg::CNT_W-1:0]          out_span_count,
  output logic [tgad_pkg::PIX_W-1:0]          out_pixel_value,
  output logic                                out_span_clipped,
  output logic                                out_image_done
);

  logic                 beat_valid, beat_take;
  tgad_pkg::tgad_beat_t beat;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  // Input register
  tgad_in_reg u_in_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_byte (in_stream_byte),
    .in_frame_start (in_frame_start),
    .beat_valid     (beat_valid),
    .beat           (beat),
    .beat_take      (beat_take)
  );

  // Packet decoder and result register
  tgad_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .beat_valid       (beat_valid),
    .beat             (beat),
    .beat_take        (beat_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_span_address (out_span_address),
    .out_span_count   (out_span_count),
    .out_pixel_value  (out_pixel_value),
    .out_span_clipped (out_span_clipped),
    .out_image_done   (out_image_done)
  );

endmodule
